### rtl/jeps_pkg.sv
`timescale 1ns / 1ps

package jeps_pkg;

   // Event type bits. The axis bit wins when both are set.
   localparam int unsigned TYPE_AXIS_BIT   = 1;
   localparam int unsigned TYPE_BUTTON_BIT = 0;

   // Axis numbers of the source device.
   localparam logic [7:0] AXIS_LEFT_X  = 8'd0;
   localparam logic [7:0] AXIS_LEFT_Y  = 8'd1;
   localparam logic [7:0] AXIS_RIGHT_X = 8'd3;
   localparam logic [7:0] AXIS_RIGHT_Y = 8'd4;
   localparam logic [7:0] AXIS_DPAD_X  = 8'd6;
   localparam logic [7:0] AXIS_DPAD_Y  = 8'd7;

   // Analog byte slots.
   localparam logic [1:0] STICK_RIGHT_X = 2'd0;
   localparam logic [1:0] STICK_RIGHT_Y = 2'd1;
   localparam logic [1:0] STICK_LEFT_X  = 2'd2;
   localparam logic [1:0] STICK_LEFT_Y  = 2'd3;

   // Button map bit positions of the d-pad.
   localparam logic [3:0] BIT_UP    = 4'd4;
   localparam logic [3:0] BIT_RIGHT = 4'd5;
   localparam logic [3:0] BIT_DOWN  = 4'd6;
   localparam logic [3:0] BIT_LEFT  = 4'd7;

   localparam int unsigned NUM_SLOTS  = 12;
   localparam int unsigned NUM_STICKS = 4;

   localparam logic [7:0]  PRESSURE_FULL  = 8'hff;
   localparam logic [7:0]  PRESSURE_NONE  = 8'h00;
   localparam logic [7:0]  STICK_CENTER   = 8'd128;
   localparam logic [15:0] BUTTONS_ALL_UP = 16'hffff;

   typedef struct packed {
      logic [15:0]                     buttons;
      logic [NUM_SLOTS-1:0][7:0]       pressure;
      logic [NUM_STICKS-1:0][7:0]      stick;
   } pad_state_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] index;
   } lookup_type;

   // Source button number to button map bit.
   function automatic lookup_type button_to_bit(logic [7:0] num);
      lookup_type r;
      r = '{hit: 1'b1, index: 4'd0};
      unique case (num)
         8'd0:    r.index = 4'd14;
         8'd1:    r.index = 4'd13;
         8'd2:    r.index = 4'd12;
         8'd3:    r.index = 4'd15;
         8'd4:    r.index = 4'd10;
         8'd5:    r.index = 4'd11;
         8'd6:    r.index = 4'd8;
         8'd7:    r.index = 4'd9;
         8'd8:    r.index = 4'd0;
         8'd9:    r.index = 4'd3;
         8'd11:   r.index = 4'd1;
         8'd12:   r.index = 4'd2;
         default: r.hit   = 1'b0;
      endcase
      return r;
   endfunction

   // Button map bit to pressure slot. Select, start, L3 and R3 have none.
   function automatic lookup_type bit_to_slot(logic [3:0] b);
      lookup_type r;
      r = '{hit: 1'b1, index: 4'd0};
      unique case (b)
         4'd4:    r.index = 4'd2;
         4'd5:    r.index = 4'd0;
         4'd6:    r.index = 4'd3;
         4'd7:    r.index = 4'd1;
         4'd8:    r.index = 4'd10;
         4'd9:    r.index = 4'd11;
         4'd10:   r.index = 4'd8;
         4'd11:   r.index = 4'd9;
         4'd12:   r.index = 4'd4;
         4'd13:   r.index = 4'd5;
         4'd14:   r.index = 4'd6;
         4'd15:   r.index = 4'd7;
         default: r.hit   = 1'b0;
      endcase
      return r;
   endfunction

endpackage

### rtl/joystick_event_to_pad_state_unit.sv
`timescale 1ns / 1ps

// A word waits in the input register, then updates the pad state and the result
// register together, where its result becomes valid.
// Throughput: one word per cycle while results are taken; with a result held,
// one more word waits in the input register and then the input stalls.
// Reset: all buttons released, pressures 0, sticks 128, no words in flight.

module joystick_event_to_pad_state_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_event_type,
   input  logic [7:0]         req_event_number,
   input  logic signed [15:0] req_event_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_button_map,
   output logic [63:0]        rsp_pressures_low,
   output logic [31:0]        rsp_pressures_high,
   output logic [31:0]        rsp_stick_bytes,
   output logic               rsp_applied
);

   logic                    in_valid_ff;
   logic [7:0]              in_type_ff;
   logic [7:0]              in_number_ff;
   logic signed [15:0]      in_value_ff;
   jeps_pkg::pad_state_type state_ff;
   jeps_pkg::pad_state_type state_in;
   logic                    upd_applied;
   logic                    rsp_valid_ff;
   logic                    rsp_applied_ff;
   jeps_pkg::pad_state_type rsp_state_ff;
   logic                    advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff   <= req_event_type;
         in_number_ff <= req_event_number;
         in_value_ff  <= req_event_value;
      end
   end

   jeps_update u_update (
      .cur_state    (state_ff),
      .event_type   (in_type_ff),
      .event_number (in_number_ff),
      .event_value  (in_value_ff),
      .nxt_state    (state_in),
      .applied      (upd_applied)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.buttons  <= jeps_pkg::BUTTONS_ALL_UP;
         state_ff.pressure <= '0;
         state_ff.stick    <= {jeps_pkg::NUM_STICKS{jeps_pkg::STICK_CENTER}};
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_state_ff   <= state_in;
         rsp_applied_ff <= upd_applied;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_button_map     = rsp_state_ff.buttons;
   assign rsp_pressures_low  = rsp_state_ff.pressure[7:0];
   assign rsp_pressures_high = rsp_state_ff.pressure[11:8];
   assign rsp_stick_bytes    = rsp_state_ff.stick;
   assign rsp_applied        = rsp_applied_ff;

   // The word on display always shows the current pad state.
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_state_ff == state_ff))
      else $error("result word does not match pad state");

   // An ignored event leaves the pad state untouched.
   a_ignored_stable: assert property (@(posedge clock) disable iff (reset)
      (advance && !upd_applied) |=> $stable(state_ff))
      else $error("ignored event changed pad state");

   // A held input word is neither lost nor altered while the result stalls.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_number_ff)))
      else $error("stalled input word was dropped");

   // The state only moves when a word is applied.
   a_state_moves_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("pad state changed without an event");

endmodule

### rtl/jeps_update.sv
`timescale 1ns / 1ps

module jeps_update (
   input  jeps_pkg::pad_state_type cur_state,
   input  logic [7:0]              event_type,
   input  logic [7:0]              event_number,
   input  logic signed [15:0]      event_value,
   output jeps_pkg::pad_state_type nxt_state,
   output logic                    applied
);

   always_comb begin
      jeps_pkg::lookup_type btn;
      jeps_pkg::lookup_type slot;
      jeps_pkg::lookup_type neg_slot;
      jeps_pkg::lookup_type pos_slot;
      logic [3:0] neg_bit;
      logic [3:0] pos_bit;
      logic       dpad_hit;
      logic       stick_hit;
      logic [1:0] stick_idx;
      logic [7:0] stick_byte;
      logic       down;

      nxt_state  = cur_state;
      applied    = 1'b0;
      dpad_hit   = 1'b0;
      stick_hit  = 1'b0;
      stick_idx  = jeps_pkg::STICK_RIGHT_X;
      neg_bit    = jeps_pkg::BIT_LEFT;
      pos_bit    = jeps_pkg::BIT_RIGHT;
      // Top byte of the value with its sign bit flipped is 128 plus value >> 8.
      stick_byte = {~event_value[15], event_value[14:8]};
      down       = (event_value != 16'sd0);
      btn        = jeps_pkg::button_to_bit(event_number);
      slot       = jeps_pkg::bit_to_slot(btn.index);

      if (event_type[jeps_pkg::TYPE_AXIS_BIT]) begin
         unique case (event_number)
            jeps_pkg::AXIS_LEFT_X: begin
               stick_hit = 1'b1;
               stick_idx = jeps_pkg::STICK_LEFT_X;
            end
            jeps_pkg::AXIS_LEFT_Y: begin
               stick_hit = 1'b1;
               stick_idx = jeps_pkg::STICK_LEFT_Y;
            end
            jeps_pkg::AXIS_RIGHT_X: begin
               stick_hit = 1'b1;
               stick_idx = jeps_pkg::STICK_RIGHT_X;
            end
            jeps_pkg::AXIS_RIGHT_Y: begin
               stick_hit = 1'b1;
               stick_idx = jeps_pkg::STICK_RIGHT_Y;
            end
            jeps_pkg::AXIS_DPAD_X: begin
               dpad_hit = 1'b1;
               neg_bit  = jeps_pkg::BIT_LEFT;
               pos_bit  = jeps_pkg::BIT_RIGHT;
            end
            jeps_pkg::AXIS_DPAD_Y: begin
               dpad_hit = 1'b1;
               neg_bit  = jeps_pkg::BIT_UP;
               pos_bit  = jeps_pkg::BIT_DOWN;
            end
            default: ;
         endcase
      end

      neg_slot = jeps_pkg::bit_to_slot(neg_bit);
      pos_slot = jeps_pkg::bit_to_slot(pos_bit);

      if (stick_hit) begin
         applied                       = 1'b1;
         nxt_state.stick[stick_idx]    = stick_byte;
      end else if (dpad_hit) begin
         // Release both directions, then press the one the sign selects.
         applied                          = 1'b1;
         nxt_state.buttons[neg_bit]       = ~event_value[15];
         nxt_state.buttons[pos_bit]       = event_value[15] | ~down;
         nxt_state.pressure[neg_slot.index] =
            event_value[15] ? jeps_pkg::PRESSURE_FULL : jeps_pkg::PRESSURE_NONE;
         nxt_state.pressure[pos_slot.index] =
            (!event_value[15] && down) ? jeps_pkg::PRESSURE_FULL
                                       : jeps_pkg::PRESSURE_NONE;
      end else if (!event_type[jeps_pkg::TYPE_AXIS_BIT] &&
                   event_type[jeps_pkg::TYPE_BUTTON_BIT] && btn.hit) begin
         applied                        = 1'b1;
         nxt_state.buttons[btn.index]   = ~down;
         if (slot.hit) begin
            nxt_state.pressure[slot.index] =
               down ? jeps_pkg::PRESSURE_FULL : jeps_pkg::PRESSURE_NONE;
         end
      end
   end

endmodule
